FILE: hdl/transparent_pixel_neighbor_fill_macros.svh
// Assertion helpers used by tpnf_merge. They assume clocking on clk and reset on rst.
`ifndef TRANSPARENT_PIXEL_NEIGHBOR_FILL_MACROS_SVH
`define TRANSPARENT_PIXEL_NEIGHBOR_FILL_MACROS_SVH
`ifndef SYNTH
`define TPNF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpnf assertion failed");
`define TPNF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpnf assertion failed");
`else
`define TPNF_ASSERT_IMP(lbl, ante, cons)
`define TPNF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/tpnf_pkg.sv
`timescale 1ns / 1ps
package tpnf_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int NBR_LANES       = 8;
  localparam int CNT_W           = $clog2(NBR_LANES + 1);
  localparam int SUM_W           = 8 + $clog2(NBR_LANES);
  localparam int RECIP_SHIFT     = 14;
  localparam int RECIP_W         = RECIP_SHIFT + 1;
  localparam int PROD_W          = SUM_W + RECIP_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic REG_FILL_ENABLE = 1'b0;

  typedef struct packed {
    logic        nz;
    logic [31:0] color;
  } tpnf_lane_t;

  function automatic logic in_palette(input logic [7:0] idx);
    in_palette = ({1'b0, idx} < 9'(PALETTE_ENTRIES));
  endfunction

  // ceil(2^14 / n): exact truncated quotient for sums up to 8 * 255
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    case (n)
      4'd1:    recip = 15'd16384;
      4'd2:    recip = 15'd8192;
      4'd3:    recip = 15'd5462;
      4'd4:    recip = 15'd4096;
      4'd5:    recip = 15'd3277;
      4'd6:    recip = 15'd2731;
      4'd7:    recip = 15'd2341;
      4'd8:    recip = 15'd2048;
      default: recip = '0;
    endcase
  endfunction

endpackage

FILE: hdl/tpnf_ram.sv
`timescale 1ns / 1ps
module tpnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tpnf_lane.sv
`timescale 1ns / 1ps
module tpnf_lane
  import tpnf_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PAL_AW-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [7:0]        rd_idx,
  output tpnf_lane_t        lane
);

  logic [31:0] ram_q;
  logic        nz;
  logic        inr;

  tpnf_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_idx[PAL_AW-1:0]),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      nz  <= (rd_idx != 8'd0);
      inr <= in_palette(rd_idx);
    end
  end

  // indices past the palette read as black
  assign lane.nz    = nz;
  assign lane.color = inr ? ram_q : 32'd0;

endmodule

FILE: hdl/tpnf_merge.sv
`timescale 1ns / 1ps
`include "transparent_pixel_neighbor_fill_macros.svh"
module tpnf_merge
  import tpnf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        fill_enable,
  input  tpnf_lane_t  center,
  input  tpnf_lane_t  nbr [NBR_LANES],
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata
);

  logic [SUM_W-1:0]   sum_r_next, sum_g_next, sum_b_next;
  logic [CNT_W-1:0]   cnt_next;
  logic               v2, v3;
  logic [SUM_W-1:0]   sum_r2, sum_g2, sum_b2;
  logic [CNT_W-1:0]   cnt2;
  logic               fill2, fill3;
  logic [31:0]        color2, color3;
  logic [RECIP_W-1:0] rcp;
  logic [PROD_W-1:0]  prod_r3, prod_g3, prod_b3;
  logic               out_ready, ready3;

  assign out_ready = !m_tvalid || m_tready;
  assign ready3    = !v3 || out_ready;
  assign in_ready  = !v2 || ready3;

  // skip neighbours at index zero, whatever entry zero holds
  always_comb begin
    sum_r_next = '0;
    sum_g_next = '0;
    sum_b_next = '0;
    cnt_next   = '0;
    for (int k = 0; k < NBR_LANES; k++) begin
      sum_r_next = sum_r_next + (nbr[k].nz ? SUM_W'(nbr[k].color[31:24]) : SUM_W'(0));
      sum_g_next = sum_g_next + (nbr[k].nz ? SUM_W'(nbr[k].color[23:16]) : SUM_W'(0));
      sum_b_next = sum_b_next + (nbr[k].nz ? SUM_W'(nbr[k].color[15:8]) : SUM_W'(0));
      cnt_next   = cnt_next + CNT_W'(nbr[k].nz);
    end
  end

  // zero count gives a zero reciprocal, so an empty neighbourhood averages to black
  assign rcp = recip(cnt2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_ready) begin
        v2 <= in_valid;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (out_ready) begin
        m_tvalid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      sum_r2 <= sum_r_next;
      sum_g2 <= sum_g_next;
      sum_b2 <= sum_b_next;
      cnt2   <= cnt_next;
      fill2  <= fill_enable && !center.nz;
      color2 <= center.color;
    end
    if (ready3) begin
      prod_r3 <= PROD_W'(sum_r2) * PROD_W'(rcp);
      prod_g3 <= PROD_W'(sum_g2) * PROD_W'(rcp);
      prod_b3 <= PROD_W'(sum_b2) * PROD_W'(rcp);
      fill3   <= fill2;
      color3  <= color2;
    end
    if (out_ready) begin
      if (fill3) begin
        m_tdata <= {8'h00, prod_b3[RECIP_SHIFT +: 8], prod_g3[RECIP_SHIFT +: 8],
                    prod_r3[RECIP_SHIFT +: 8]};
      end else begin
        m_tdata <= {color3[7:0], color3[15:8], color3[23:16], color3[31:24]};
      end
    end
  end

  `TPNF_ASSERT_IMP(a_stall_only_when_full, !in_ready, v2 && v3 && m_tvalid && !m_tready)
  `TPNF_ASSERT_NXT(a_stage_advances, v2 && ready3, v3)
  `TPNF_ASSERT_IMP(a_empty_sum_zero, v2 && (cnt2 == '0), (sum_r2 | sum_g2 | sum_b2) == '0)
  `TPNF_ASSERT_IMP(a_quotient_fits, v3 && fill3, (prod_r3 >> (RECIP_SHIFT + 8)) == '0)

endmodule

FILE: hdl/transparent_pixel_neighbor_fill.sv
`timescale 1ns / 1ps
// Paletted pixel to RGBA converter with transparent-pixel neighbour fill. Load beats
// (tuser 0) write one palette entry and give no result; pixel beats (tuser 1) give one
// RGBA beat. The block takes one beat every cycle while m_tready does not hold it back, and
// a pixel's result is formed by the palette read at the accepting edge (nine palette
// copies, one per lane with one read port each, so the centre and all eight neighbours
// are read in the same cycle), followed by a sum stage, a reciprocal multiply stage and
// the output register. Every load writes all copies at once. The palette has no reset
// and needs no clearing pass; read only entries that have been loaded. fill_enable sits
// at APB address 0.
module transparent_pixel_neighbor_fill
  import tpnf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // center_index, nbr_up_left, nbr_left, nbr_down_left, nbr_up, nbr_down,
  // nbr_up_right, nbr_right, nbr_down_right, entry_address (8 each), entry_color (32)
  input  logic [111:0] s_tdata,
  // command
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_red, out_green, out_blue, out_alpha (8 each)
  output logic [31:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic       fill_enable;
  logic       v1;
  logic       ready1;
  logic       merge_ready;
  logic       accept;
  logic       wr_en;
  logic [7:0] entry_address;
  tpnf_lane_t center_lane;
  tpnf_lane_t nbr_lane [NBR_LANES];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FILL_ENABLE) ? {31'd0, fill_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FILL_ENABLE)) begin
      fill_enable <= pwdata[0];
    end
  end

  assign ready1        = !v1 || merge_ready;
  assign s_tready      = ready1;
  assign accept        = s_tvalid && s_tready;
  assign entry_address = s_tdata[79:72];
  // drop loads aimed past the end of the palette
  assign wr_en         = accept && (s_tuser == CMD_LOAD) && in_palette(entry_address);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= s_tvalid && (s_tuser == CMD_PIXEL);
    end
  end

  tpnf_lane u_center (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(entry_address[PAL_AW-1:0]),
    .wr_data(s_tdata[111:80]),
    .rd_en  (ready1),
    .rd_idx (s_tdata[7:0]),
    .lane   (center_lane)
  );

  for (genvar k = 0; k < NBR_LANES; k++) begin : g_nbr
    tpnf_lane u_lane (
      .clk    (clk),
      .wr_en  (wr_en),
      .wr_addr(entry_address[PAL_AW-1:0]),
      .wr_data(s_tdata[111:80]),
      .rd_en  (ready1),
      .rd_idx (s_tdata[8*(k+1) +: 8]),
      .lane   (nbr_lane[k])
    );
  end

  tpnf_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v1),
    .in_ready   (merge_ready),
    .fill_enable(fill_enable),
    .center     (center_lane),
    .nbr        (nbr_lane),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
